// File: rtl/olist_pkg.sv
// Package for the ordered list engine: operation and status codes, field widths,
// and the command and status structs between the controller and the datapath.
// No dependencies.
package olist_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 5;
    localparam int DEPTH_DEF = 16;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_DUMP   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [1:0] RD_ZERO = 2'd0;
    localparam logic [1:0] RD_NEXT = 2'd1;
    localparam logic [1:0] RD_SKIP = 2'd2;

    localparam logic WR_APPEND = 1'b0;
    localparam logic WR_SHIFT  = 1'b1;

    localparam logic [1:0] EMIT_STATUS = 2'd0;
    localparam logic [1:0] EMIT_HIT    = 2'd1;
    localparam logic [1:0] EMIT_ENTRY  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       clr_idx;
        logic       inc_idx;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic       wr_sel;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       emit;
        logic [1:0] emit_kind;
        logic [1:0] status_code;
    } cmd_t;

    typedef struct packed {
        logic       cnt_zero;
        logic       cnt_full;
        logic       match;
        logic       idx_last;
        logic       idx_pen;
        logic       out_free;
        logic [1:0] op;
    } sts_t;

endpackage

// File: rtl/ordered_list_engine.sv
// Ordered list engine: a bounded list of signed 32-bit values kept in list order.
// Instantiates olist_ctrl and olist_dp; depends on olist_pkg.
//
// The input channel carries one transaction per command: operation (append,
// delete, search, dump) and value. A transaction is taken when in_valid is high
// and in_stall is low; in_stall is high while a command is still being worked.
// The output channel gives status, position, entry_value and last per result,
// taken when out_valid is high and out_stall is low. Append, delete and search
// give one result; dump gives one result per entry, head first, last marked, and
// one status result on an empty list. Append and commands on an empty list give
// their result through the controller state and then the result register. Search
// and delete read one entry per cycle from the entry memory; delete then closes
// the gap with one read and one write per cycle. Dump delivers one entry per cycle
// while the result register is free. The result register decouples the channels:
// a new transaction is accepted while a result waits, and a stalled result holds
// until taken; dump and each result step pause while the result register is
// full and stalled. Reset empties the list and drops any pending result.
module ordered_list_engine
#(
    parameter int DEPTH = olist_pkg::DEPTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           operation,
    input  logic signed [olist_pkg::DATA_W-1:0]  value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic [olist_pkg::POS_W-1:0]          position,
    output logic signed [olist_pkg::DATA_W-1:0]  entry_value,
    output logic                                 last
);

    olist_pkg::cmd_t cmd;
    olist_pkg::sts_t sts;

    olist_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .sts       (sts),
        .cmd       (cmd)
    );

    olist_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .operation   (operation),
        .value       (value),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .position    (position),
        .entry_value (entry_value),
        .last        (last)
    );

endmodule

// File: rtl/olist_ctrl.sv
// Controller of the ordered list engine: accepts transactions and sequences
// append, scan, compaction and dump steps. Depends on olist_pkg.
module olist_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        operation,
    input  olist_pkg::sts_t   sts,
    output olist_pkg::cmd_t   cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_APPEND  = 3'd1;
    localparam logic [2:0] S_EMPTY   = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_SHIFT   = 3'd4;
    localparam logic [2:0] S_DELDONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load    = 1'b1;
                    cmd.clr_idx = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = olist_pkg::RD_ZERO;
                    if (operation == olist_pkg::OP_APPEND)
                        state_next = S_APPEND;
                    else if (sts.cnt_zero)
                        state_next = S_EMPTY;
                    else
                        state_next = S_SCAN;
                end
            end
            S_APPEND:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = olist_pkg::EMIT_STATUS;
                    if (sts.cnt_full)
                    begin
                        cmd.status_code = olist_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.status_code = olist_pkg::ST_OK;
                        cmd.wr_en       = 1'b1;
                        cmd.wr_sel      = olist_pkg::WR_APPEND;
                        cmd.cnt_inc     = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = olist_pkg::EMIT_STATUS;
                    cmd.status_code = olist_pkg::ST_EMPTY;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (sts.op == olist_pkg::OP_DUMP)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = olist_pkg::EMIT_ENTRY;
                        if (sts.idx_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.inc_idx = 1'b1;
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = olist_pkg::RD_NEXT;
                        end
                    end
                end
                else if (sts.match)
                begin
                    if (sts.op == olist_pkg::OP_SEARCH)
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = olist_pkg::EMIT_HIT;
                            state_next    = S_IDLE;
                        end
                    end
                    else if (sts.idx_last)
                    begin
                        state_next = S_DELDONE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = olist_pkg::RD_NEXT;
                        state_next = S_SHIFT;
                    end
                end
                else if (sts.idx_last)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_kind   = olist_pkg::EMIT_STATUS;
                        cmd.status_code = olist_pkg::ST_NOT_FOUND;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.inc_idx = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = olist_pkg::RD_NEXT;
                end
            end
            S_SHIFT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = olist_pkg::WR_SHIFT;
                if (sts.idx_pen)
                begin
                    state_next = S_DELDONE;
                end
                else
                begin
                    cmd.inc_idx = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = olist_pkg::RD_SKIP;
                end
            end
            S_DELDONE:
            begin
                if (sts.out_free)
                begin
                    cmd.cnt_dec     = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = olist_pkg::EMIT_STATUS;
                    cmd.status_code = olist_pkg::ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/olist_dp.sv
// Datapath of the ordered list engine: entry memory, entry count, scan index
// and the result register. Depends on olist_pkg.
module olist_dp
#(
    parameter int DEPTH = olist_pkg::DEPTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [1:0]                           operation,
    input  logic signed [olist_pkg::DATA_W-1:0]  value,
    input  olist_pkg::cmd_t                      cmd,
    output olist_pkg::sts_t                      sts,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic [olist_pkg::POS_W-1:0]          position,
    output logic signed [olist_pkg::DATA_W-1:0]  entry_value,
    output logic                                 last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = olist_pkg::POS_W;

    logic signed [olist_pkg::DATA_W-1:0] mem [DEPTH];

    logic [1:0]                          op_reg;
    logic signed [olist_pkg::DATA_W-1:0] val_reg;
    logic signed [olist_pkg::DATA_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]                    cnt_reg;
    logic [CNT_W-1:0]                    cnt_next;
    logic [CNT_W-1:0]                    idx_reg;
    logic [CNT_W-1:0]                    idx_next;
    logic                                out_valid_reg;
    logic [1:0]                          status_reg;
    logic [POS_W-1:0]                    position_reg;
    logic signed [olist_pkg::DATA_W-1:0] entry_value_reg;
    logic                                last_reg;

    logic [CNT_W-1:0]                    idx_p1;
    logic [CNT_W:0]                      idx_p2;
    logic [POS_W+CNT_W-1:0]              pos_wide;
    logic [IDX_W-1:0]                    rd_addr;
    logic [IDX_W-1:0]                    wr_addr;
    logic signed [olist_pkg::DATA_W-1:0] wr_data;
    logic                                out_free;

    assign idx_p1   = idx_reg + CNT_W'(1);
    assign idx_p2   = {1'b0, idx_reg} + (CNT_W + 1)'(2);
    assign pos_wide = {{POS_W{1'b0}}, idx_p1};
    assign out_free = !out_valid_reg || !out_stall;

    assign sts.cnt_zero = (cnt_reg == '0);
    assign sts.cnt_full = (cnt_reg == CNT_W'(DEPTH));
    assign sts.match    = (rd_data_reg == val_reg);
    assign sts.idx_last = (idx_p1 == cnt_reg);
    assign sts.idx_pen  = (idx_p2 == {1'b0, cnt_reg});
    assign sts.out_free = out_free;
    assign sts.op       = op_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            olist_pkg::RD_NEXT: rd_addr = idx_p1[IDX_W-1:0];
            olist_pkg::RD_SKIP: rd_addr = idx_p2[IDX_W-1:0];
            default:            rd_addr = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.wr_sel == olist_pkg::WR_SHIFT)
        begin
            wr_addr = idx_reg[IDX_W-1:0];
            wr_data = rd_data_reg;
        end
        else
        begin
            wr_addr = cnt_reg[IDX_W-1:0];
            wr_data = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            val_reg <= value;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (cmd.cnt_dec)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.clr_idx)
            idx_next = '0;
        else if (cmd.inc_idx)
            idx_next = idx_p1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.emit_kind)
                olist_pkg::EMIT_HIT:
                begin
                    status_reg      <= olist_pkg::ST_OK;
                    position_reg    <= pos_wide[POS_W-1:0];
                    entry_value_reg <= '0;
                    last_reg        <= 1'b1;
                end
                olist_pkg::EMIT_ENTRY:
                begin
                    status_reg      <= olist_pkg::ST_OK;
                    position_reg    <= pos_wide[POS_W-1:0];
                    entry_value_reg <= rd_data_reg;
                    last_reg        <= sts.idx_last;
                end
                default:
                begin
                    status_reg      <= cmd.status_code;
                    position_reg    <= '0;
                    entry_value_reg <= '0;
                    last_reg        <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_value = entry_value_reg;
    assign last        = last_reg;

endmodule

// File: tb/ordered_list_checker.sv
`timescale 1ns / 100ps
// Checker for the ordered list engine: watches both channels, keeps its own copy of the
// list, predicts the results of every accepted command and compares them in order.
// Depends on olist_pkg for the operation and status codes and the field widths.
module ordered_list_checker
    import olist_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [1:0]               operation,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [1:0]               status,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] entry_value,
    input  logic                     last,
    output int                       mismatch_count,
    output int                       pending_results,
    output int                       results_seen
);

    typedef struct packed {
        logic [1:0]        status;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] entry_value;
        logic              last;
    } list_result_t;

    logic signed [DATA_W-1:0] list_mem [DEPTH];
    int                       list_len = 0;
    list_result_t             expected_results [$];
    list_result_t             head_result;
    int                       errors = 0;
    int                       checked = 0;

    function automatic list_result_t make_result(input logic [1:0] st,
                                                 input int pos,
                                                 input logic [DATA_W-1:0] val,
                                                 input logic lst);
        list_result_t r;
        r.status      = st;
        r.position    = POS_W'(pos);
        r.entry_value = val;
        r.last        = lst;
        return r;
    endfunction

    task automatic predict_list_op(input logic [1:0] op, input logic signed [DATA_W-1:0] v);
        int hit;
        hit = -1;
        for (int i = 0; i < list_len; i++)
        begin
            if (hit < 0 && list_mem[i] == v)
                hit = i;
        end
        if (op == OP_APPEND)
        begin
            if (list_len >= DEPTH)
                expected_results.push_back(make_result(ST_FULL, 0, '0, 1'b1));
            else
            begin
                list_mem[list_len] = v;
                list_len++;
                expected_results.push_back(make_result(ST_OK, 0, '0, 1'b1));
            end
        end
        else if (list_len == 0)
            expected_results.push_back(make_result(ST_EMPTY, 0, '0, 1'b1));
        else if (op == OP_DUMP)
        begin
            for (int i = 0; i < list_len; i++)
                expected_results.push_back(make_result(ST_OK, i + 1, list_mem[i],
                                                       i == list_len - 1));
        end
        else if (hit < 0)
            expected_results.push_back(make_result(ST_NOT_FOUND, 0, '0, 1'b1));
        else if (op == OP_SEARCH)
            expected_results.push_back(make_result(ST_OK, hit + 1, '0, 1'b1));
        else
        begin
            for (int i = hit; i + 1 < list_len; i++)
                list_mem[i] = list_mem[i + 1];
            list_len--;
            expected_results.push_back(make_result(ST_OK, 0, '0, 1'b1));
        end
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_len = 0;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                checked++;
                if (expected_results.size() == 0)
                begin
                    $error("Result transaction arrived with no result outstanding");
                    errors++;
                end
                else
                begin
                    head_result = expected_results.pop_front();
                    check_field("status", DATA_W'(head_result.status), DATA_W'(status));
                    check_field("position", DATA_W'(head_result.position),
                                DATA_W'(position));
                    check_field("entry_value", head_result.entry_value, entry_value);
                    check_field("last", DATA_W'(head_result.last), DATA_W'(last));
                end
            end
            if (in_valid && !in_stall)
                predict_list_op(operation, value);
        end
        mismatch_count  <= errors;
        pending_results <= expected_results.size();
        results_seen    <= checked;
    end

endmodule

// File: tb/tb_ordered_list_engine.sv
`timescale 1ns / 100ps
// Top of the ordered list engine testbench: clock, reset, command stimulus and result
// stalls, with the verdict at the end. Depends on olist_pkg, ordered_list_engine and
// ordered_list_checker.
module tb_ordered_list_engine;
    import olist_pkg::*;

    localparam int MIX_FILL    = 0;
    localparam int MIX_DRAIN   = 1;
    localparam int MIX_EVEN    = 2;
    localparam int RANDOM_OPS  = 75;
    localparam int LONG_HOLD   = 80;
    localparam int DRAIN_WAIT  = 24;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               operation = OP_APPEND;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               status;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] entry_value;
    logic                     last;

    int mismatch_count;
    int pending_results;
    int results_seen;
    int op_count [4] = '{default: 0};
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    ordered_list_engine uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .position    (position),
        .entry_value (entry_value),
        .last        (last)
    );

    ordered_list_checker list_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .value           (value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .position        (position),
        .entry_value     (entry_value),
        .last            (last),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_seen    (results_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // The result side stalls in short random bursts, and once for a long stretch so that
    // the engine fills up and stalls its own input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_op(input logic [1:0] op, input logic signed [DATA_W-1:0] v);
        operation <= op;
        value     <= v;
        in_valid  <= 1'b1;
        op_count[op]++;
        do
            @(posedge clk);
        while (in_stall);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    function automatic logic [1:0] pick_operation(input int mix);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                return (roll < 75) ? OP_APPEND : (roll < 85) ? OP_DELETE :
                       (roll < 93) ? OP_SEARCH : OP_DUMP;
            MIX_DRAIN:
                return (roll < 15) ? OP_APPEND : (roll < 70) ? OP_DELETE :
                       (roll < 85) ? OP_SEARCH : OP_DUMP;
            default:
                return (roll < 30) ? OP_APPEND : (roll < 55) ? OP_DELETE :
                       (roll < 80) ? OP_SEARCH : OP_DUMP;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] pool_val;
        pool_val = $urandom_range(0, 7);
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return pool_val - 32'sd4;
        endcase
    endfunction

    initial
    begin
        int mix;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Commands on an empty list.
        send_op(OP_DUMP, $urandom);
        send_op(OP_DELETE, 32'sd7);
        send_op(OP_SEARCH, 32'sd7);

        // Extreme values and a duplicate, then hits, misses and first-match delete.
        send_op(OP_APPEND, 32'sh8000_0000);
        send_op(OP_APPEND, 32'sh7fff_ffff);
        send_op(OP_APPEND, 32'sd5);
        send_op(OP_APPEND, -32'sd1);
        send_op(OP_APPEND, 32'sd5);
        send_op(OP_SEARCH, 32'sd5);
        send_op(OP_SEARCH, 32'sd99);
        send_op(OP_DELETE, 32'sd99);
        send_op(OP_DELETE, 32'sd5);
        send_op(OP_DUMP, $urandom);

        // Fill the list, append once more to a full list and dump all of it.
        repeat (12) send_op(OP_APPEND, $urandom);
        send_op(OP_APPEND, 32'sd1);
        send_op(OP_DUMP, $urandom);

        mix = MIX_DRAIN;
        for (int k = 0; k < RANDOM_OPS; k++)
        begin
            if (k % 20 == 0)
                mix = $urandom_range(MIX_FILL, MIX_EVEN);
            if (k == 35)
                hold_req = 1'b1;
            if (k == RANDOM_OPS - 20)
                idle_on = 1'b0;
            send_op(pick_operation(mix), pick_value());
        end
        in_valid <= 1'b0;

        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Commands sent: %0d append, %0d delete, %0d search, %0d dump.",
                 op_count[OP_APPEND], op_count[OP_DELETE], op_count[OP_SEARCH],
                 op_count[OP_DUMP]);
        $display("Result transactions checked: %0d, including a long output hold.",
                 results_seen);
        if (mismatch_count == 0 && pending_results == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
rtl/olist_pkg.sv
rtl/olist_ctrl.sv
rtl/olist_dp.sv
rtl/ordered_list_engine.sv
tb/ordered_list_checker.sv
tb/tb_ordered_list_engine.sv
